FILE: rtl/core/bsp_pkg.sv
`timescale 1ns / 1ps
// Shared constants and payload types of the cubic B-spline path sampler.
package bsp_pkg;

    localparam int COORD_W         = 32;
    localparam int CFG_W           = 6;
    localparam int MAX_SAMPLES_DEF = 32;

    localparam logic [CFG_W-1:0] SPS_RESET = CFG_W'(8);

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      path_end;
    } point_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] sample_x;
        logic signed [COORD_W-1:0] sample_y;
        logic                      run_last;
        logic                      path_done;
    } sample_t;

endpackage

FILE: rtl/core/bsp_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready stream channel carrying one payload struct per transaction.
interface bsp_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/cubic_bspline_path_sampler_top.sv
`timescale 1ns / 1ps
// Uniform cubic B-spline path sampler: top level with sequencer and shared datapath.
//
// Usage:
//   waypoint (sink, point_t): one path point per transaction, Q16.16 x/y plus path_end.
//   curve (source, sample_t): smoothed samples, Q16.16, with run_last / path_done.
//   cfg_we / cfg_wdata: samples_per_span, written while the block is idle
//   (0 acts as 1, values above MAX_SAMPLES act as MAX_SAMPLES).
//
// waypoint.ready is high only in IDLE; one point is worked on at a time.
// From the fourth point of a path on, each point yields S samples. Each sample
// runs on one shared 33 x (WGT_W+1) multiplier and one restoring divider
// (one quotient bit per cycle): weight steps, then per axis MAC steps and divide
// steps, then an output step. Points that only fill the window are shifted in
// without leaving IDLE; path_end passes points through at one per cycle while
// curve.ready is high. If curve.ready is low the result is held and the
// sequencer waits. Reset (rst_n low, asynchronous) clears the window, the point
// count and the sequencer, and sets samples_per_span to 8.
module cubic_bspline_path_sampler_top
    import bsp_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    bsp_stream_if.sink       waypoint,
    bsp_stream_if.source     curve
);

    // widths: s, S up to MAX_SAMPLES; weights over the common denominator 6*S^3
    localparam int SAMP_W = $clog2(MAX_SAMPLES + 1);
    localparam int POW_W  = 3 * SAMP_W;
    localparam int WGT_W  = POW_W + 3;
    localparam int ACC_W  = COORD_W + WGT_W;
    localparam int MAG_W  = ACC_W - 1;
    localparam int STEP_W = $clog2(MAG_W + 1);

    // sequencer step codes
    localparam logic [STEP_W-1:0] PS_SS    = STEP_W'(0);
    localparam logic [STEP_W-1:0] PS_S3    = STEP_W'(1);
    localparam logic [STEP_W-1:0] WS_SQ    = STEP_W'(0);
    localparam logic [STEP_W-1:0] WS_S3    = STEP_W'(1);
    localparam logic [STEP_W-1:0] WS_S2S   = STEP_W'(2);
    localparam logic [STEP_W-1:0] WS_UU    = STEP_W'(3);
    localparam logic [STEP_W-1:0] WS_U3    = STEP_W'(4);
    localparam logic [STEP_W-1:0] WS_W2    = STEP_W'(5);
    localparam logic [STEP_W-1:0] MS_FIRST = STEP_W'(1);
    localparam logic [STEP_W-1:0] MS_LAST  = STEP_W'(4);
    localparam logic [STEP_W-1:0] DS_INIT  = STEP_W'(0);
    localparam logic [STEP_W-1:0] DS_LAST  = STEP_W'(MAG_W);

    localparam logic [1:0] SEEN_FULL = 2'd3;
    localparam logic [1:0] IDX_NEW   = 2'd3;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_PREP = 7'b0000010,
        ST_WGT  = 7'b0000100,
        ST_MAC  = 7'b0001000,
        ST_DIV  = 7'b0010000,
        ST_OUT  = 7'b0100000,
        ST_PASS = 7'b1000000
    } state_t;

    // control state
    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [CFG_W-1:0]    spn_reg;
    logic [SAMP_W-1:0]   span_reg;
    logic [SAMP_W-1:0]   s_reg;
    logic [1:0]          idx_reg;
    logic [1:0]          seen_reg;
    logic                axis_reg;
    logic signed [COORD_W-1:0] win_x_reg [0:2];
    logic signed [COORD_W-1:0] win_y_reg [0:2];

    // datapath
    logic signed [COORD_W-1:0] px_reg, py_reg;
    logic                      end_reg;
    logic [2*SAMP_W-1:0]       t_reg;
    logic [POW_W-1:0]          s3_reg, s2s_reg, big_s3_reg;
    logic [WGT_W-1:0]          den_reg;
    logic [WGT_W-1:0]          wgt_reg [0:3];
    logic signed [ACC_W-1:0]   prod_reg, acc_reg;
    logic [MAG_W-1:0]          dq_reg;
    logic [WGT_W-1:0]          rem_reg;
    logic                      neg_reg;
    logic signed [COORD_W-1:0] sx_reg, sy_reg;

    logic                      in_acc;
    logic                      out_acc;
    logic [SAMP_W-1:0]         span_clamped;
    logic [SAMP_W-1:0]         u_val;
    logic                      last_s;
    logic [1:0]                mac_k;
    logic signed [COORD_W-1:0] mac_pt;
    logic signed [COORD_W:0]   mul_a;
    logic signed [WGT_W:0]     mul_b;
    logic signed [ACC_W+1:0]   mul_p;
    logic [WGT_W-1:0]          w1_calc;
    logic [WGT_W-1:0]          w2_calc;
    logic [WGT_W:0]            div_shift;
    logic                      div_ge;
    logic [WGT_W-1:0]          rem_next;
    logic [MAG_W-1:0]          dq_next;
    logic signed [COORD_W-1:0] div_res;
    logic                      win_shift;
    logic                      win_clear;
    logic signed [COORD_W-1:0] shift_x, shift_y;
    logic signed [COORD_W-1:0] pass_x, pass_y;

    assign in_acc  = waypoint.valid && waypoint.ready;
    assign out_acc = curve.valid && curve.ready;

    always_comb
    begin
        if (spn_reg == '0)
            span_clamped = SAMP_W'(1);
        else if (spn_reg > CFG_W'(MAX_SAMPLES))
            span_clamped = SAMP_W'(MAX_SAMPLES);
        else
            span_clamped = SAMP_W'(spn_reg);
    end

    assign u_val  = span_reg - s_reg;
    assign last_s = (s_reg == span_reg - SAMP_W'(1));
    assign mac_k  = step_reg[1:0];

    // point feeding the MAC for weight k on the current axis
    always_comb
    begin
        case (mac_k)
            2'd0:    mac_pt = axis_reg ? win_y_reg[0] : win_x_reg[0];
            2'd1:    mac_pt = axis_reg ? win_y_reg[1] : win_x_reg[1];
            2'd2:    mac_pt = axis_reg ? win_y_reg[2] : win_x_reg[2];
            default: mac_pt = axis_reg ? py_reg : px_reg;
        endcase
    end

    // shared multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_PREP:
            begin
                if (step_reg == PS_SS)
                    mul_a = (COORD_W + 1)'(span_reg);
                else
                    mul_a = (COORD_W + 1)'(t_reg);
                mul_b = (WGT_W + 1)'(span_reg);
            end
            ST_WGT:
            begin
                unique case (step_reg)
                    WS_SQ:
                    begin
                        mul_a = (COORD_W + 1)'(s_reg);
                        mul_b = (WGT_W + 1)'(s_reg);
                    end
                    WS_S3:
                    begin
                        mul_a = (COORD_W + 1)'(t_reg);
                        mul_b = (WGT_W + 1)'(s_reg);
                    end
                    WS_S2S:
                    begin
                        mul_a = (COORD_W + 1)'(t_reg);
                        mul_b = (WGT_W + 1)'(span_reg);
                    end
                    WS_UU:
                    begin
                        mul_a = (COORD_W + 1)'(u_val);
                        mul_b = (WGT_W + 1)'(u_val);
                    end
                    WS_U3:
                    begin
                        mul_a = (COORD_W + 1)'(t_reg);
                        mul_b = (WGT_W + 1)'(u_val);
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            ST_MAC:
            begin
                mul_a = (COORD_W + 1)'(mac_pt);
                mul_b = signed'({1'b0, wgt_reg[mac_k]});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // w1 = 4S^3 + 3s^3 - 6s^2 S; w2 closes the sum to 6S^3 (mod 2^WGT_W is exact)
    assign w1_calc = WGT_W'({big_s3_reg, 2'b00}) + WGT_W'({s3_reg, 1'b0}) + WGT_W'(s3_reg)
                   - WGT_W'({s2s_reg, 2'b00}) - WGT_W'({s2s_reg, 1'b0});
    assign w2_calc = den_reg - wgt_reg[0] - wgt_reg[1] - wgt_reg[3];

    // restoring divider step; floor for negatives via one's complement in and out
    assign div_shift = {rem_reg, dq_reg[MAG_W-1]};
    assign div_ge    = (div_shift >= {1'b0, den_reg});
    assign rem_next  = div_ge ? WGT_W'(div_shift - {1'b0, den_reg}) : div_shift[WGT_W-1:0];
    assign dq_next   = {dq_reg[MAG_W-2:0], div_ge};
    assign div_res   = neg_reg ? ~dq_next[COORD_W-1:0] : dq_next[COORD_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (seen_reg == SEEN_FULL)
                        state_next = ST_PREP;
                    else if (waypoint.data.path_end)
                        state_next = ST_PASS;
                end
            end
            ST_PREP:
                if (step_reg == PS_S3)
                    state_next = ST_WGT;
            ST_WGT:
                if (step_reg == WS_W2)
                    state_next = ST_MAC;
            ST_MAC:
                if (step_reg == MS_LAST)
                    state_next = ST_DIV;
            ST_DIV:
                if (step_reg == DS_LAST)
                    state_next = axis_reg ? ST_OUT : ST_MAC;
            ST_OUT:
            begin
                if (out_acc)
                begin
                    if (!last_s)
                        state_next = ST_WGT;
                    else if (end_reg)
                        state_next = ST_PASS;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_PASS:
                if (out_acc && idx_reg == IDX_NEW)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // window update: shift in a point that ends no path, clear after path_end
    assign win_shift = (state_reg == ST_IDLE && in_acc && seen_reg != SEEN_FULL
                        && !waypoint.data.path_end)
                    || (state_reg == ST_OUT && out_acc && last_s && !end_reg);
    assign win_clear = (state_reg == ST_PASS && out_acc && idx_reg == IDX_NEW);
    assign shift_x   = (state_reg == ST_IDLE) ? waypoint.data.point_x : px_reg;
    assign shift_y   = (state_reg == ST_IDLE) ? waypoint.data.point_y : py_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            spn_reg   <= SPS_RESET;
            span_reg  <= SAMP_W'(1);
            s_reg     <= '0;
            idx_reg   <= '0;
            seen_reg  <= '0;
            axis_reg  <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                win_x_reg[i] <= '0;
                win_y_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= (state_next != state_reg) ? '0 : step_reg + STEP_W'(1);

            if (cfg_we)
                spn_reg <= cfg_wdata;

            if (state_reg == ST_IDLE && in_acc)
            begin
                span_reg <= span_clamped;
                s_reg    <= '0;
                idx_reg  <= IDX_NEW - seen_reg;
            end

            if (state_reg == ST_WGT)
                axis_reg <= 1'b0;
            else if (state_reg == ST_DIV && step_reg == DS_LAST)
                axis_reg <= 1'b1;

            if (state_reg == ST_OUT && out_acc)
            begin
                if (!last_s)
                    s_reg <= s_reg + SAMP_W'(1);
                idx_reg <= IDX_NEW;
            end

            if (state_reg == ST_PASS && out_acc && idx_reg != IDX_NEW)
                idx_reg <= idx_reg + 2'd1;

            if (win_clear)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    win_x_reg[i] <= '0;
                    win_y_reg[i] <= '0;
                end
                seen_reg <= '0;
            end
            else if (win_shift)
            begin
                win_x_reg[0] <= win_x_reg[1];
                win_x_reg[1] <= win_x_reg[2];
                win_x_reg[2] <= shift_x;
                win_y_reg[0] <= win_y_reg[1];
                win_y_reg[1] <= win_y_reg[2];
                win_y_reg[2] <= shift_y;
                if (seen_reg != SEEN_FULL)
                    seen_reg <= seen_reg + 2'd1;
            end
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_acc)
        begin
            px_reg  <= waypoint.data.point_x;
            py_reg  <= waypoint.data.point_y;
            end_reg <= waypoint.data.path_end;
        end

        unique case (state_reg)
            ST_PREP:
            begin
                if (step_reg == PS_SS)
                    t_reg <= mul_p[2*SAMP_W-1:0];
                else
                begin
                    big_s3_reg <= mul_p[POW_W-1:0];
                    den_reg    <= WGT_W'({mul_p[POW_W-1:0], 2'b00})
                                + WGT_W'({mul_p[POW_W-1:0], 1'b0});
                end
            end
            ST_WGT:
            begin
                unique case (step_reg)
                    WS_SQ:  t_reg   <= mul_p[2*SAMP_W-1:0];
                    WS_S3:  s3_reg  <= mul_p[POW_W-1:0];
                    WS_S2S: s2s_reg <= mul_p[POW_W-1:0];
                    WS_UU:  t_reg   <= mul_p[2*SAMP_W-1:0];
                    WS_U3:
                    begin
                        wgt_reg[0] <= WGT_W'(mul_p[POW_W-1:0]);
                        wgt_reg[1] <= w1_calc;
                        wgt_reg[3] <= WGT_W'(s3_reg);
                    end
                    WS_W2:  wgt_reg[2] <= w2_calc;
                    default: ;
                endcase
            end
            ST_MAC:
            begin
                // product registered in prod_reg, then accumulated into acc_reg; acc starts at den/2
                if (step_reg != MS_LAST)
                    prod_reg <= mul_p[ACC_W-1:0];
                if (step_reg == MS_FIRST)
                    acc_reg <= ACC_W'(den_reg >> 1) + prod_reg;
                else if (step_reg != '0)
                    acc_reg <= acc_reg + prod_reg;
            end
            ST_DIV:
            begin
                if (step_reg == DS_INIT)
                begin
                    neg_reg <= acc_reg[ACC_W-1];
                    dq_reg  <= acc_reg[ACC_W-1] ? ~acc_reg[MAG_W-1:0] : acc_reg[MAG_W-1:0];
                    rem_reg <= '0;
                end
                else
                begin
                    rem_reg <= rem_next;
                    dq_reg  <= dq_next;
                    if (step_reg == DS_LAST)
                    begin
                        if (axis_reg)
                            sy_reg <= div_res;
                        else
                            sx_reg <= div_res;
                    end
                end
            end
            default: ;
        endcase
    end

    // pass-through source: stored window entry, or the new point itself
    always_comb
    begin
        case (idx_reg)
            2'd0:
            begin
                pass_x = win_x_reg[0];
                pass_y = win_y_reg[0];
            end
            2'd1:
            begin
                pass_x = win_x_reg[1];
                pass_y = win_y_reg[1];
            end
            2'd2:
            begin
                pass_x = win_x_reg[2];
                pass_y = win_y_reg[2];
            end
            default:
            begin
                pass_x = px_reg;
                pass_y = py_reg;
            end
        endcase
    end

    assign waypoint.ready = (state_reg == ST_IDLE);
    assign curve.valid    = (state_reg == ST_OUT) || (state_reg == ST_PASS);

    always_comb
    begin
        if (state_reg == ST_PASS)
        begin
            curve.data.sample_x  = pass_x;
            curve.data.sample_y  = pass_y;
            curve.data.run_last  = (idx_reg == IDX_NEW);
            curve.data.path_done = (idx_reg == IDX_NEW);
        end
        else
        begin
            curve.data.sample_x  = sx_reg;
            curve.data.sample_y  = sy_reg;
            curve.data.run_last  = !end_reg && last_s;
            curve.data.path_done = 1'b0;
        end
    end

endmodule
